// ===== sv/pose_chain_composer_top_macros.svh =====
// Assertion macros used by the pose chain composer controller.
// Depends on nothing; a module that uses the macros has clk and arst_n in scope.
`ifndef POSE_CHAIN_COMPOSER_TOP_MACROS_SVH
`define POSE_CHAIN_COMPOSER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pcc_pkg.sv =====
// Shared types and constants of the pose chain composer.
// Used by the controller, the datapath and the top level; depends on nothing.
package pcc_pkg;

	// Quaternion fraction bits (Q1.14) and the shift that undoes a rotation.
	localparam int QUAT_FRAC = 14;
	localparam int ROT_SHIFT = 2 * QUAT_FRAC;

	// Controller states: idle, one per step of the multiply schedule, rounding and output.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TA,
		ST_TB,
		ST_Q1,
		ST_CA,
		ST_CB,
		ST_CC,
		ST_Q2,
		ST_Q3,
		ST_RND,
		ST_OUT
	} state_t;

	// Operand group fed to the four shared multipliers.
	typedef enum logic [3:0] {
		MG_NONE,
		MG_TA,
		MG_TB,
		MG_Q1,
		MG_CA,
		MG_CB,
		MG_CC,
		MG_Q2,
		MG_Q3
	} mul_grp_t;

	// Accumulation applied to the products registered in the previous cycle.
	typedef enum logic [3:0] {
		PO_NONE,
		PO_TA,
		PO_TB,
		PO_Q1,
		PO_CA,
		PO_CB,
		PO_CC,
		PO_Q2,
		PO_Q3
	} post_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		mul_grp_t mul_grp;
		post_op_t post_op;
		logic     pos_round;
		logic     pos_add;
		logic     finish;
	} dp_cmd_t;

endpackage

// ===== sv/pcc_ctrl.sv =====
// Controller of the pose chain composer: schedule state machine and output valid.
// Depends on pcc_pkg and pose_chain_composer_top_macros.svh.
`include "pose_chain_composer_top_macros.svh"

module pcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pcc_pkg::dp_cmd_t  cmd
);
	import pcc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.finish || (out_valid_q && !out_ready);
		end
	end

	// Next state: a fixed walk through the schedule, waiting at the end for a free slot.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) begin
				state_d = ST_TA;
			end
			ST_TA:  state_d = ST_TB;
			ST_TB:  state_d = ST_Q1;
			ST_Q1:  state_d = ST_CA;
			ST_CA:  state_d = ST_CB;
			ST_CB:  state_d = ST_CC;
			ST_CC:  state_d = ST_Q2;
			ST_Q2:  state_d = ST_Q3;
			ST_Q3:  state_d = ST_RND;
			ST_RND: state_d = ST_OUT;
			ST_OUT: if (slot_free) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands for each state.
	always_comb begin
		cmd.load      = 1'b0;
		cmd.mul_grp   = MG_NONE;
		cmd.post_op   = PO_NONE;
		cmd.pos_round = 1'b0;
		cmd.pos_add   = 1'b0;
		cmd.finish    = 1'b0;
		unique case (state_q)
			ST_IDLE: cmd.load = accept;
			ST_TA:   cmd.mul_grp = MG_TA;
			ST_TB: begin
				cmd.mul_grp = MG_TB;
				cmd.post_op = PO_TA;
			end
			ST_Q1: begin
				cmd.mul_grp = MG_Q1;
				cmd.post_op = PO_TB;
			end
			ST_CA: begin
				cmd.mul_grp = MG_CA;
				cmd.post_op = PO_Q1;
			end
			ST_CB: begin
				cmd.mul_grp = MG_CB;
				cmd.post_op = PO_CA;
			end
			ST_CC: begin
				cmd.mul_grp = MG_CC;
				cmd.post_op = PO_CB;
			end
			ST_Q2: begin
				cmd.mul_grp = MG_Q2;
				cmd.post_op = PO_CC;
			end
			ST_Q3: begin
				cmd.mul_grp   = MG_Q3;
				cmd.post_op   = PO_Q2;
				cmd.pos_round = 1'b1;
			end
			ST_RND: begin
				cmd.post_op = PO_Q3;
				cmd.pos_add = 1'b1;
			end
			ST_OUT:  cmd.finish = slot_free;
			default: cmd.load = 1'b0;
		endcase
	end

	// An accepted item always starts the schedule in the next cycle.
	`PCC_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_TA,
		"accepted item did not start the schedule")
	// A result is written only into a free or draining output register.
	`PCC_ASSERT_NOW(a_finish_slot_free, cmd.finish, slot_free,
		"result written over an untaken result")
	// Every finished item shows up as a valid result.
	`PCC_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_q,
		"finished item not presented")
	// A blocked final step keeps waiting instead of dropping the item.
	`PCC_ASSERT_NEXT(a_wait_holds, state_q == ST_OUT && !slot_free, state_q == ST_OUT,
		"final step left while output was blocked")

endmodule

// ===== sv/pcc_dp.sv =====
// Datapath of the pose chain composer: parent pose, four shared multipliers,
// accumulators, rounding, saturation and the output register. Depends on pcc_pkg.
module pcc_dp #(
	parameter int PW = 24,
	parameter int QW = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pcc_pkg::dp_cmd_t        cmd,
	input  logic                    in_chain_start,
	input  logic signed [PW-1:0]    in_pos [3],
	input  logic signed [QW-1:0]    in_quat [4],
	output logic signed [PW-1:0]    world_pos [3],
	output logic signed [QW-1:0]    world_quat [4]
);
	import pcc_pkg::*;

	// Derived widths: t = 2 (u x v), products, accumulators and rounded values.
	localparam int T_W    = PW + QW + 2;
	localparam int PR_W   = QW + T_W;
	localparam int D_W    = PR_W + 1;
	localparam int QS_W   = 2 * QW + 2;
	localparam int ACC_W  = (((PW + ROT_SHIFT) > D_W) ? (PW + ROT_SHIFT) : D_W) + 2;
	localparam int RND_W  = ACC_W - ROT_SHIFT;
	localparam int SUM_W  = ((RND_W > PW) ? RND_W : PW) + 1;
	localparam int QR_W   = QS_W - QUAT_FRAC;
	localparam int HALF_P = 1 << (ROT_SHIFT - 1);
	localparam int HALF_Q = 1 << (QUAT_FRAC - 1);
	localparam int ONE_Q  = 1 << QUAT_FRAC;
	localparam logic [PW-1:0] P_MAX = {1'b0, {(PW - 1){1'b1}}};
	localparam logic [PW-1:0] P_MIN = {1'b1, {(PW - 1){1'b0}}};
	localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW - 1){1'b1}}};
	localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW - 1){1'b0}}};

	logic signed [PW-1:0]    pp_q [3];
	logic signed [QW-1:0]    pq_q [4];
	logic signed [PW-1:0]    lp_q [3];
	logic signed [QW-1:0]    lq_q [4];
	logic signed [T_W-1:0]   t_q [3];
	logic signed [PR_W-1:0]  prod_s1 [4];
	logic signed [ACC_W-1:0] acc_q [3];
	logic signed [QS_W-1:0]  qs_q [4];
	logic signed [RND_W-1:0] rnd_q [3];
	logic signed [PW-1:0]    wp_q [3];
	logic signed [PW-1:0]    out_pos_q [3];
	logic signed [QW-1:0]    out_quat_q [4];

	logic signed [T_W-1:0]   vx [3];
	logic signed [T_W-1:0]   lx [4];
	logic signed [QW-1:0]    ma [4];
	logic signed [T_W-1:0]   mb [4];
	logic signed [ACC_W-1:0] pa [4];
	logic signed [D_W-1:0]   pd [4];
	logic signed [QS_W-1:0]  pqq [4];
	logic signed [D_W-1:0]   d01;
	logic signed [D_W-1:0]   d23;
	logic signed [T_W-1:0]   t01;
	logic signed [T_W-1:0]   t23;
	logic signed [ACC_W-1:0] vs [3];
	logic signed [ACC_W-1:0] racc [3];
	logic signed [SUM_W-1:0] psum [3];
	logic signed [PW-1:0]    psat [3];
	logic signed [QS_W-1:0]  qracc [4];
	logic signed [QR_W-1:0]  qr [4];
	logic signed [QW-1:0]    qsat [4];

	// Local operands widened to the multiplier's second input; local position scaled for the accumulators.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vx[i] = {{(T_W - PW){lp_q[i][PW-1]}}, lp_q[i]};
			vs[i] = {{(ACC_W - PW - ROT_SHIFT){lp_q[i][PW-1]}}, lp_q[i], {ROT_SHIFT{1'b0}}};
		end
		for (int i = 0; i < 4; i++) begin
			lx[i] = {{(T_W - QW){lq_q[i][QW-1]}}, lq_q[i]};
		end
	end

	// Operand selection for the four shared multipliers.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ma[i] = '0;
			mb[i] = '0;
		end
		unique case (cmd.mul_grp)
			MG_TA: begin
				ma[0] = pq_q[1]; mb[0] = vx[2];
				ma[1] = pq_q[2]; mb[1] = vx[1];
				ma[2] = pq_q[2]; mb[2] = vx[0];
				ma[3] = pq_q[0]; mb[3] = vx[2];
			end
			MG_TB: begin
				ma[0] = pq_q[0]; mb[0] = vx[1];
				ma[1] = pq_q[1]; mb[1] = vx[0];
				ma[2] = pq_q[3]; mb[2] = lx[0];
				ma[3] = pq_q[0]; mb[3] = lx[3];
			end
			MG_Q1: begin
				ma[0] = pq_q[1]; mb[0] = lx[2];
				ma[1] = pq_q[2]; mb[1] = lx[1];
				ma[2] = pq_q[3]; mb[2] = lx[1];
				ma[3] = pq_q[0]; mb[3] = lx[2];
			end
			MG_CA: begin
				ma[0] = pq_q[1]; mb[0] = t_q[2];
				ma[1] = pq_q[2]; mb[1] = t_q[1];
				ma[2] = pq_q[2]; mb[2] = t_q[0];
				ma[3] = pq_q[0]; mb[3] = t_q[2];
			end
			MG_CB: begin
				ma[0] = pq_q[0]; mb[0] = t_q[1];
				ma[1] = pq_q[1]; mb[1] = t_q[0];
				ma[2] = pq_q[3]; mb[2] = t_q[0];
				ma[3] = pq_q[3]; mb[3] = t_q[1];
			end
			MG_CC: begin
				ma[0] = pq_q[3]; mb[0] = t_q[2];
				ma[1] = pq_q[1]; mb[1] = lx[3];
				ma[2] = pq_q[2]; mb[2] = lx[0];
				ma[3] = pq_q[3]; mb[3] = lx[2];
			end
			MG_Q2: begin
				ma[0] = pq_q[0]; mb[0] = lx[1];
				ma[1] = pq_q[1]; mb[1] = lx[0];
				ma[2] = pq_q[2]; mb[2] = lx[3];
				ma[3] = pq_q[3]; mb[3] = lx[3];
			end
			MG_Q3: begin
				ma[0] = pq_q[0]; mb[0] = lx[0];
				ma[1] = pq_q[1]; mb[1] = lx[1];
				ma[2] = pq_q[2]; mb[2] = lx[2];
			end
			default: ma[0] = '0;
		endcase
	end

	// Registered products in the views the accumulations need.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pa[i]  = {{(ACC_W - PR_W){prod_s1[i][PR_W-1]}}, prod_s1[i]};
			pd[i]  = {prod_s1[i][PR_W-1], prod_s1[i]};
			pqq[i] = prod_s1[i][QS_W-1:0];
		end
		d01 = pd[0] - pd[1];
		d23 = pd[2] - pd[3];
		t01 = {d01[T_W-2:0], 1'b0};
		t23 = {d23[T_W-2:0], 1'b0};
	end

	// Position rounding, parent add and saturation.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			racc[i] = acc_q[i] + ACC_W'(HALF_P);
			psum[i] = {{(SUM_W - RND_W){rnd_q[i][RND_W-1]}}, rnd_q[i]}
				+ {{(SUM_W - PW){pp_q[i][PW-1]}}, pp_q[i]};
			if (psum[i][SUM_W-1:PW-1] != {(SUM_W - PW + 1){psum[i][SUM_W-1]}}) begin
				psat[i] = psum[i][SUM_W-1] ? P_MIN : P_MAX;
			end else begin
				psat[i] = psum[i][PW-1:0];
			end
		end
	end

	// Quaternion rounding and saturation.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qracc[i] = qs_q[i] + QS_W'(HALF_Q);
			qr[i]    = qracc[i][QS_W-1:QUAT_FRAC];
			if (qr[i][QR_W-1:QW-1] != {(QR_W - QW + 1){qr[i][QR_W-1]}}) begin
				qsat[i] = qr[i][QR_W-1] ? Q_MIN : Q_MAX;
			end else begin
				qsat[i] = qr[i][QW-1:0];
			end
		end
	end

	// Parent pose: identity on a chain start, the finished world pose otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pp_q[i] <= '0;
				pq_q[i] <= '0;
			end
			pq_q[3] <= QW'(ONE_Q);
		end else if (cmd.load && in_chain_start) begin
			for (int i = 0; i < 3; i++) begin
				pp_q[i] <= '0;
				pq_q[i] <= '0;
			end
			pq_q[3] <= QW'(ONE_Q);
		end else if (cmd.finish) begin
			for (int i = 0; i < 3; i++) begin
				pp_q[i] <= wp_q[i];
			end
			for (int i = 0; i < 4; i++) begin
				pq_q[i] <= qsat[i];
			end
		end
	end

	// Local pose capture, multiplier registers, accumulations and output register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				lp_q[i] <= in_pos[i];
			end
			for (int i = 0; i < 4; i++) begin
				lq_q[i] <= in_quat[i];
			end
		end
		for (int i = 0; i < 4; i++) begin
			prod_s1[i] <= ma[i] * mb[i];
		end
		case (cmd.post_op)
			PO_TA: begin
				t_q[0] <= t01;
				t_q[1] <= t23;
			end
			PO_TB: begin
				t_q[2]  <= t01;
				qs_q[0] <= pqq[2] + pqq[3];
			end
			PO_Q1: begin
				qs_q[0] <= qs_q[0] + pqq[0] - pqq[1];
				qs_q[1] <= pqq[2] - pqq[3];
			end
			PO_CA: begin
				acc_q[0] <= vs[0] + pa[0] - pa[1];
				acc_q[1] <= vs[1] + pa[2] - pa[3];
			end
			PO_CB: begin
				acc_q[2] <= vs[2] + pa[0] - pa[1];
				acc_q[0] <= acc_q[0] + pa[2];
				acc_q[1] <= acc_q[1] + pa[3];
			end
			PO_CC: begin
				acc_q[2] <= acc_q[2] + pa[0];
				qs_q[1]  <= qs_q[1] + pqq[1] + pqq[2];
				qs_q[2]  <= pqq[3];
			end
			PO_Q2: begin
				qs_q[2] <= qs_q[2] + pqq[0] - pqq[1] + pqq[2];
				qs_q[3] <= pqq[3];
			end
			PO_Q3: begin
				qs_q[3] <= qs_q[3] - pqq[0] - pqq[1] - pqq[2];
			end
			default: ;
		endcase
		if (cmd.pos_round) begin
			for (int i = 0; i < 3; i++) begin
				rnd_q[i] <= racc[i][ACC_W-1:ROT_SHIFT];
			end
		end
		if (cmd.pos_add) begin
			for (int i = 0; i < 3; i++) begin
				wp_q[i] <= psat[i];
			end
		end
		if (cmd.finish) begin
			for (int i = 0; i < 3; i++) begin
				out_pos_q[i] <= wp_q[i];
			end
			for (int i = 0; i < 4; i++) begin
				out_quat_q[i] <= qsat[i];
			end
		end
	end

	assign world_pos  = out_pos_q;
	assign world_quat = out_quat_q;

endmodule

// ===== sv/pose_chain_composer_top.sv =====
// Channel  Signals                       Content
// s_axis   tvalid tready tdata tuser     local joint pose, chain start flag
// m_axis   tvalid tready tdata           world pose of the joint
//
// An accepted item walks through eight product groups on four shared multipliers,
// each accumulated in the cycle after it, then the parent add and the quaternion
// rounding into the output register. A new item is accepted only once the state
// machine is back in idle after the result has been written, so items do not overlap.
// Reset clears the parent pose to the origin with the identity orientation.
// A new item is accepted and worked on while a result waits in the output
// register; its last step waits there until the sink takes the older result.
// Top level of the pose chain composer; depends on pcc_pkg, pcc_ctrl and pcc_dp.
module pose_chain_composer_top #(
	parameter int POSITION_WIDTH   = 24,
	parameter int QUATERNION_WIDTH = 16,
	localparam int FIELDS_WIDTH    = 3 * POSITION_WIDTH + 4 * QUATERNION_WIDTH,
	localparam int TDATA_WIDTH     = ((FIELDS_WIDTH + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// local_pos_x, local_pos_y, local_pos_z, local_quat_x, local_quat_y,
	// local_quat_z, local_quat_w, zero fill
	input  logic [TDATA_WIDTH-1:0] s_axis_tdata,
	// chain_start
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// world_pos_x, world_pos_y, world_pos_z, world_quat_x, world_quat_y,
	// world_quat_z, world_quat_w, zero fill
	output logic [TDATA_WIDTH-1:0] m_axis_tdata
);
	import pcc_pkg::*;

	localparam int QUAT_BASE = 3 * POSITION_WIDTH;

	dp_cmd_t                             cmd;
	logic signed [POSITION_WIDTH-1:0]    in_pos [3];
	logic signed [QUATERNION_WIDTH-1:0]  in_quat [4];
	logic signed [POSITION_WIDTH-1:0]    world_pos [3];
	logic signed [QUATERNION_WIDTH-1:0]  world_quat [4];

	// Unpack the input item.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_pos[i] = s_axis_tdata[i*POSITION_WIDTH +: POSITION_WIDTH];
		end
		for (int i = 0; i < 4; i++) begin
			in_quat[i] = s_axis_tdata[QUAT_BASE + i*QUATERNION_WIDTH +: QUATERNION_WIDTH];
		end
	end

	// Pack the result item, zero fill on top.
	assign m_axis_tdata = TDATA_WIDTH'({world_quat[3], world_quat[2], world_quat[1],
		world_quat[0], world_pos[2], world_pos[1], world_pos[0]});

	pcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	pcc_dp #(
		.PW (POSITION_WIDTH),
		.QW (QUATERNION_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.in_chain_start (s_axis_tuser),
		.in_pos         (in_pos),
		.in_quat        (in_quat),
		.world_pos      (world_pos),
		.world_quat     (world_quat)
	);

endmodule

// ===== dv/pose_chain_composer_top_tb.sv =====
// Self-checking testbench for pose_chain_composer_top: joint poses go in on the input stream and
// each world pose is checked against a fixed-point forward-kinematics predictor kept in the bench.
// Depends on pcc_pkg and on the RTL of the pose chain composer; reads no files.
module pose_chain_composer_top_tb;
	import pcc_pkg::*;

	localparam int POS_W       = 24;
	localparam int QUAT_W      = 16;
	localparam int FIELDS_W    = 3 * POS_W + 4 * QUAT_W;
	localparam int TDATA_W     = ((FIELDS_W + 7) / 8) * 8;
	localparam int POS_FRAC    = 16;
	localparam longint ONE_Q   = longint'(1) <<< QUAT_FRAC;
	localparam int POS_MAX     = (1 << (POS_W - 1)) - 1;
	localparam int POS_MIN     = -(1 << (POS_W - 1));
	localparam int ONE_P       = 1 << POS_FRAC;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 20;

	// One joint: its pose in the parent frame and the flag that starts a chain.
	typedef struct {
		logic                     chain_start;
		logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;
		logic signed [QUAT_W-1:0] quat_x, quat_y, quat_z, quat_w;
	} joint_pose_t;

	// World pose of a joint as the block returns it.
	typedef struct {
		logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;
		logic signed [QUAT_W-1:0] quat_x, quat_y, quat_z, quat_w;
	} world_pose_t;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata;
	logic               s_axis_tuser;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;

	// Parent pose of the next joint, as the predictor tracks it.
	longint chain_pos[3]  = '{0, 0, 0};
	longint chain_quat[4] = '{0, 0, 0, ONE_Q};

	world_pose_t expected_world[$];
	int          error_count = 0;
	int          burst_left  = 0;
	int          hold_request = 0;

	pose_chain_composer_top #(
		.POSITION_WIDTH  (POS_W),
		.QUATERNION_WIDTH(QUAT_W)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// Clock with a period of 10.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Floor of x / 2^s after adding one half, so halves round up.
	function automatic longint round_half_up(longint x, int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp_signed(longint x, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (x > hi) begin
			return hi;
		end
		if (x < lo) begin
			return lo;
		end
		return x;
	endfunction

	// Composes a joint with the tracked parent pose and makes the result the new parent.
	function automatic world_pose_t compose_pose(joint_pose_t j);
		longint      pp[3];
		longint      pq[4];
		longint      v[3];
		longint      lq[4];
		longint      t[3];
		longint      c[3];
		longint      acc;
		longint      wq[4];
		world_pose_t w;
		if (j.chain_start) begin
			pp = '{0, 0, 0};
			pq = '{0, 0, 0, ONE_Q};
		end else begin
			pp = chain_pos;
			pq = chain_quat;
		end
		v  = '{longint'(j.pos_x), longint'(j.pos_y), longint'(j.pos_z)};
		lq = '{longint'(j.quat_x), longint'(j.quat_y), longint'(j.quat_z),
			longint'(j.quat_w)};

		// Rotation of the local position: v + w*t + u x t, with t = 2 (u x v).
		t[0] = 2 * (pq[1] * v[2] - pq[2] * v[1]);
		t[1] = 2 * (pq[2] * v[0] - pq[0] * v[2]);
		t[2] = 2 * (pq[0] * v[1] - pq[1] * v[0]);
		c[0] = pq[1] * t[2] - pq[2] * t[1];
		c[1] = pq[2] * t[0] - pq[0] * t[2];
		c[2] = pq[0] * t[1] - pq[1] * t[0];
		for (int i = 0; i < 3; i++) begin
			acc = (v[i] <<< ROT_SHIFT) + pq[3] * t[i] + c[i];
			chain_pos[i] = clamp_signed(round_half_up(acc, ROT_SHIFT) + pp[i], POS_W);
		end

		// Orientation is the Hamilton product parent * local.
		wq[0] = pq[3] * lq[0] + pq[0] * lq[3] + pq[1] * lq[2] - pq[2] * lq[1];
		wq[1] = pq[3] * lq[1] - pq[0] * lq[2] + pq[1] * lq[3] + pq[2] * lq[0];
		wq[2] = pq[3] * lq[2] + pq[0] * lq[1] - pq[1] * lq[0] + pq[2] * lq[3];
		wq[3] = pq[3] * lq[3] - pq[0] * lq[0] - pq[1] * lq[1] - pq[2] * lq[2];
		for (int i = 0; i < 4; i++) begin
			chain_quat[i] = clamp_signed(round_half_up(wq[i], QUAT_FRAC), QUAT_W);
		end

		w.pos_x  = POS_W'(chain_pos[0]);
		w.pos_y  = POS_W'(chain_pos[1]);
		w.pos_z  = POS_W'(chain_pos[2]);
		w.quat_x = QUAT_W'(chain_quat[0]);
		w.quat_y = QUAT_W'(chain_quat[1]);
		w.quat_z = QUAT_W'(chain_quat[2]);
		w.quat_w = QUAT_W'(chain_quat[3]);
		return w;
	endfunction

	function automatic joint_pose_t make_joint(bit start, int px, int py, int pz,
		int qx, int qy, int qz, int qw);
		joint_pose_t j;
		j.chain_start = start;
		j.pos_x  = POS_W'(px);
		j.pos_y  = POS_W'(py);
		j.pos_z  = POS_W'(pz);
		j.quat_x = QUAT_W'(qx);
		j.quat_y = QUAT_W'(qy);
		j.quat_z = QUAT_W'(qz);
		j.quat_w = QUAT_W'(qw);
		return j;
	endfunction

	// Mostly small positions, some over the full range, a few at the edges.
	function automatic int rand_pos_value();
		int edges[7] = '{POS_MIN, -1, 0, 1, POS_MAX, ONE_P, -ONE_P};
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			return int'($urandom_range(0, 2 << 20)) - (1 << 20);
		end else if (kind < 90) begin
			return int'($urandom_range(0, (1 << POS_W) - 1)) + POS_MIN;
		end
		return edges[$urandom_range(0, 6)];
	endfunction

	// Random joint; the orientation is mostly near unit length, the rest is raw content.
	function automatic joint_pose_t rand_joint(bit start);
		int          edges[7] = '{-32768, -16384, -1, 0, 1, 16384, 32767};
		real         a[4];
		real         norm;
		int          qv[4];
		int          kind;
		joint_pose_t j;
		kind = $urandom_range(0, 99);
		for (int i = 0; i < 4; i++) begin
			if (kind < 60) begin
				a[i] = real'(int'($urandom_range(0, 32768)) - 16384);
			end else if (kind < 80) begin
				qv[i] = int'($urandom_range(0, 32768)) - 16384;
			end else if (kind < 90) begin
				qv[i] = int'($urandom_range(0, 65535)) - 32768;
			end else begin
				qv[i] = edges[$urandom_range(0, 6)];
			end
		end
		if (kind < 60) begin
			norm = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
			if (norm < 1.0) begin
				qv = '{0, 0, 0, 16384};
			end else begin
				for (int i = 0; i < 4; i++) begin
					qv[i] = $rtoi(a[i] * 16384.0 / norm);
				end
			end
		end
		j = make_joint(start, rand_pos_value(), rand_pos_value(), rand_pos_value(),
			qv[0], qv[1], qv[2], qv[3]);
		return j;
	endfunction

	// Offers one joint and records its world pose once the block takes it.
	task automatic send_joint(joint_pose_t j);
		logic [TDATA_W-1:0] data;
		data = '0;
		data[FIELDS_W-1:0] = {j.quat_w, j.quat_z, j.quat_y, j.quat_x, j.pos_z, j.pos_y, j.pos_x};
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= j.chain_start;
		do @(posedge clk); while (!s_axis_tready);
		expected_world.push_back(compose_pose(j));
	endtask

	// Bursts of items with random gaps between them, sometimes long unbroken runs.
	task automatic pace_sender();
		int gap;
		int kind;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		kind = $urandom_range(0, 9);
		gap = (kind < 6) ? $urandom_range(1, 3) : (kind < 9) ? $urandom_range(4, 12) :
			$urandom_range(20, 40);
		s_axis_tvalid <= 1'b0;
		repeat (gap) @(posedge clk);
		burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) :
			$urandom_range(1, 16);
	endtask

	task automatic send_paced(joint_pose_t j);
		send_joint(j);
		pace_sender();
	endtask

	// Stops offering until every world pose in flight has come back.
	task automatic wait_results_done();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_world.size() != 0);
		burst_left = 0;
	endtask

	// Root joints at the extremes of position and orientation.
	task automatic test_root_extremes();
		send_paced(make_joint(1, POS_MAX, POS_MIN, 0, 0, 0, 0, 16384));
		send_paced(make_joint(1, -1, 1, POS_MIN, 16384, 0, 0, 0));
		send_paced(make_joint(1, 0, 0, 0, -16384, -16384, -16384, -16384));
	endtask

	// A chain of quarter turns and small odd offsets that exercise rounding.
	task automatic test_chain_rotation();
		send_paced(make_joint(1, ONE_P, 0, 0, 0, 0, 11585, 11585));
		send_paced(make_joint(0, ONE_P, 0, 0, 0, 0, 11585, 11585));
		send_paced(make_joint(0, 0, ONE_P, 2 * ONE_P - 1, 0, 11585, 0, 11585));
		send_paced(make_joint(0, 3, -5, 7, 1, -1, 1, 16383));
		send_paced(make_joint(0, -3, 5, -7, 3, 5, -7, 16381));
	endtask

	// Parent near the limits so the world position clips at both ends.
	task automatic test_position_saturation();
		send_paced(make_joint(1, POS_MAX, POS_MAX, POS_MIN, 0, 0, 0, 16384));
		send_paced(make_joint(0, POS_MAX, 0, POS_MIN, 0, 0, 0, 16384));
		send_paced(make_joint(0, 1, 1, -1, 0, 0, 0, 16384));
	endtask

	// Orientations far from unit length, used without normalization, then a fresh root.
	task automatic test_nonunit_orientation();
		send_paced(make_joint(1, 0, 0, 0, 32767, 32767, 32767, 32767));
		send_paced(make_joint(0, 0, 0, 0, 32767, -32768, 32767, -32768));
		send_paced(make_joint(0, POS_MAX, POS_MIN, POS_MAX, 0, 0, 0, 16384));
		send_paced(make_joint(0, POS_MIN, POS_MIN, POS_MIN, -32768, -32768, -32768, -32768));
		send_paced(make_joint(0, 1, 0, 0, 0, 0, 0, 16384));
		send_paced(make_joint(1, 0, 0, 0, 0, 0, 0, 16384));
	endtask

	// The sink holds off for a long stretch while joints keep coming, so the input stalls.
	task automatic test_sink_holdoff();
		hold_request = 400;
		for (int i = 0; i < 40; i++) begin
			send_joint(rand_joint((i % 8) == 0));
		end
		wait_results_done();
	endtask

	// Random chains: mostly a root followed by children, with broken chains and stray starts.
	task automatic test_random_chains(int count);
		int  sent;
		int  chain_len;
		bit  start;
		sent = 0;
		while (sent < count) begin
			chain_len = $urandom_range(1, 12);
			for (int k = 0; k < chain_len; k++) begin
				start = (k == 0) && ($urandom_range(0, 9) != 0);
				if ($urandom_range(0, 19) == 0) begin
					start = 1'($urandom_range(0, 1));
				end
				send_paced(rand_joint(start));
				sent++;
				if (sent % 250 == 0) begin
					wait_results_done();
				end
			end
		end
	endtask

	// Receiver: phases of random length with their own acceptance rate, plus the long hold-off.
	always @(posedge clk) begin
		static int hold_left  = 0;
		static int phase_left = 0;
		static int ready_pct  = 100;
		static int rates[4]   = '{100, 90, 60, 30};
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(8, 120);
				ready_pct  = rates[$urandom_range(0, 3)];
			end
			phase_left--;
			m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
		end
	end

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			error_count++;
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
		end
	endfunction

	// Each world pose taken from the block is compared with the oldest expected one.
	always @(posedge clk) begin
		world_pose_t got;
		world_pose_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pos_x  = m_axis_tdata[0 +: POS_W];
			got.pos_y  = m_axis_tdata[POS_W +: POS_W];
			got.pos_z  = m_axis_tdata[2 * POS_W +: POS_W];
			got.quat_x = m_axis_tdata[3 * POS_W +: QUAT_W];
			got.quat_y = m_axis_tdata[3 * POS_W + QUAT_W +: QUAT_W];
			got.quat_z = m_axis_tdata[3 * POS_W + 2 * QUAT_W +: QUAT_W];
			got.quat_w = m_axis_tdata[3 * POS_W + 3 * QUAT_W +: QUAT_W];
			if (expected_world.size() == 0) begin
				error_count++;
				$error("world pose returned with none expected");
			end else begin
				want = expected_world.pop_front();
				check_field("world_pos_x", want.pos_x, got.pos_x);
				check_field("world_pos_y", want.pos_y, got.pos_y);
				check_field("world_pos_z", want.pos_z, got.pos_z);
				check_field("world_quat_x", want.quat_x, got.quat_x);
				check_field("world_quat_y", want.quat_y, got.quat_y);
				check_field("world_quat_z", want.quat_z, got.quat_z);
				check_field("world_quat_w", want.quat_w, got.quat_w);
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Reset, then the tests in turn, then the final verdict.
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_root_extremes();
		test_chain_rotation();
		test_position_saturation();
		test_nonunit_orientation();
		wait_results_done();
		test_sink_holdoff();
		test_random_chains(1000);

		wait_results_done();
		repeat (SETTLE) @(posedge clk);
		if (expected_world.size() != 0) begin
			error_count++;
			$error("%0d world poses never returned", expected_world.size());
		end
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== pose_chain_composer_top.f =====
+incdir+sv
sv/pcc_pkg.sv
sv/pcc_ctrl.sv
sv/pcc_dp.sv
sv/pose_chain_composer_top.sv
dv/pose_chain_composer_top_tb.sv
